FILE: hw/rtl/swpt_pkg.sv
// package for the move-to-front stack: payload words, op and status codes,
// controller states and the command/status bundles between controller and datapath
// no dependencies
package swpt_pkg;

    // fixed field widths of the channels and the register port
    localparam int VALUE_W  = 32;
    localparam int DATA_W   = 32;
    localparam int FILL_W   = 5;
    localparam int CFG_W    = 32;
    localparam int PADDR_W  = 3;

    // register index and reset value
    localparam logic              REG_COMPARE_MASK = 1'b0;
    localparam logic [CFG_W-1:0]  MASK_RESET       = 32'hFFFF_FFFF;

    // operation codes
    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_POP     = 2'd1,
        OP_PROMOTE = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [2:0] {
        STAT_DONE     = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_ONTOP    = 3'd3,
        STAT_NOTFOUND = 3'd4
    } status_t;

    // input word
    typedef struct packed {
        op_t                func;
        logic [VALUE_W-1:0] value;
    } in_word_t;

    // result word
    typedef struct packed {
        status_t            status;
        logic [DATA_W-1:0]  data;
        logic [FILL_W-1:0]  fill;
    } out_word_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_POP_RD,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_TOP_WR,
        S_RESP
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic    capture;      // latch op and key of an accepted word
        logic    wr_push;      // write key at the fill position
        logic    occ_inc;
        logic    occ_dec;
        logic    occ_clr;
        logic    rd_top;       // read the top entry
        logic    rd_ptr;       // read the entry at the pointer
        logic    rd_ptr_next;  // read the entry above the pointer
        logic    ptr_load_top;
        logic    ptr_dec;
        logic    ptr_inc;
        logic    hold_load;    // keep the matched entry
        logic    wr_shift;     // move the read entry down to the pointer
        logic    wr_top;       // put the kept entry on top
        logic    data_load;    // popped entry into the result data
        logic    status_load;
        status_t status_val;
        logic    out_load;     // fill the output register
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        op_t  func;
        logic is_empty;
        logic is_full;
        logic hit;          // read entry matches the key under the mask
        logic at_top;       // pointer is at the top entry
        logic ptr_zero;
        logic shift_last;   // entry above the pointer is the top one
        logic out_free;     // output register can take a word
    } dp_stat_t;

endpackage

FILE: hw/rtl/swpt_regs.sv
// configuration register block: compare mask behind an apb-style port
// depends on swpt_pkg
module swpt_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [swpt_pkg::PADDR_W-1:0] paddr,
    input  logic [swpt_pkg::CFG_W-1:0]   pwdata,
    output logic [swpt_pkg::CFG_W-1:0]   prdata,
    output logic                         pready,
    output logic [swpt_pkg::CFG_W-1:0]   compare_mask
);

    logic [swpt_pkg::CFG_W-1:0] cmask_reg;
    logic                       sel_mask;

    // word index decode
    assign sel_mask = (paddr[swpt_pkg::PADDR_W-1] == swpt_pkg::REG_COMPARE_MASK);
    assign pready   = 1'b1;

    // register write on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmask_reg <= swpt_pkg::MASK_RESET;
        end else if (psel && penable && pwrite && pready && sel_mask) begin
            cmask_reg <= pwdata;
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (sel_mask) begin
            prdata = cmask_reg;
        end
    end

    assign compare_mask = cmask_reg;

endmodule

FILE: hw/rtl/swpt_ctrl.sv
// controller state machine for the move-to-front stack
// depends on swpt_pkg; drives swpt_dp through ctrl_cmd_t
module swpt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  swpt_pkg::dp_stat_t stat,
    output swpt_pkg::ctrl_cmd_t cmd
);

    swpt_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= swpt_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            swpt_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = swpt_pkg::S_EXEC;
                end
            end
            swpt_pkg::S_EXEC: begin
                unique case (stat.func)
                    swpt_pkg::OP_POP: begin
                        state_next = stat.is_empty ? swpt_pkg::S_RESP : swpt_pkg::S_POP_RD;
                    end
                    swpt_pkg::OP_PROMOTE: begin
                        state_next = stat.is_empty ? swpt_pkg::S_RESP : swpt_pkg::S_SRCH_RD;
                    end
                    default: begin
                        state_next = swpt_pkg::S_RESP;
                    end
                endcase
            end
            swpt_pkg::S_POP_RD:  state_next = swpt_pkg::S_RESP;
            swpt_pkg::S_SRCH_RD: state_next = swpt_pkg::S_SRCH_CMP;
            swpt_pkg::S_SRCH_CMP: begin
                priority if (stat.hit && stat.at_top) begin
                    state_next = swpt_pkg::S_RESP;
                end else if (stat.hit) begin
                    state_next = swpt_pkg::S_SHIFT_RD;
                end else if (stat.ptr_zero) begin
                    state_next = swpt_pkg::S_RESP;
                end else begin
                    state_next = swpt_pkg::S_SRCH_RD;
                end
            end
            swpt_pkg::S_SHIFT_RD: state_next = swpt_pkg::S_SHIFT_WR;
            swpt_pkg::S_SHIFT_WR: begin
                state_next = stat.shift_last ? swpt_pkg::S_TOP_WR : swpt_pkg::S_SHIFT_RD;
            end
            swpt_pkg::S_TOP_WR: state_next = swpt_pkg::S_RESP;
            swpt_pkg::S_RESP: begin
                if (stat.out_free) begin
                    state_next = swpt_pkg::S_IDLE;
                end
            end
            default: state_next = swpt_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd        = '0;
        cmd.status_val = swpt_pkg::STAT_DONE;
        s_ready    = 1'b0;
        unique case (state_reg)
            swpt_pkg::S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            swpt_pkg::S_EXEC: begin
                cmd.status_load = 1'b1;
                unique case (stat.func)
                    swpt_pkg::OP_PUSH: begin
                        if (stat.is_full) begin
                            cmd.status_val = swpt_pkg::STAT_FULL;
                        end else begin
                            cmd.wr_push = 1'b1;
                            cmd.occ_inc = 1'b1;
                        end
                    end
                    swpt_pkg::OP_POP: begin
                        if (stat.is_empty) begin
                            cmd.status_val = swpt_pkg::STAT_EMPTY;
                        end else begin
                            cmd.rd_top  = 1'b1;
                            cmd.occ_dec = 1'b1;
                        end
                    end
                    swpt_pkg::OP_PROMOTE: begin
                        if (stat.is_empty) begin
                            cmd.status_val = swpt_pkg::STAT_EMPTY;
                        end else begin
                            cmd.ptr_load_top = 1'b1;
                        end
                    end
                    default: begin
                        cmd.occ_clr = 1'b1;
                    end
                endcase
            end
            swpt_pkg::S_POP_RD: begin
                cmd.data_load = 1'b1;
            end
            swpt_pkg::S_SRCH_RD: begin
                cmd.rd_ptr = 1'b1;
            end
            swpt_pkg::S_SRCH_CMP: begin
                priority if (stat.hit && stat.at_top) begin
                    cmd.status_load = 1'b1;
                    cmd.status_val  = swpt_pkg::STAT_ONTOP;
                end else if (stat.hit) begin
                    cmd.hold_load = 1'b1;
                end else if (stat.ptr_zero) begin
                    cmd.status_load = 1'b1;
                    cmd.status_val  = swpt_pkg::STAT_NOTFOUND;
                end else begin
                    cmd.ptr_dec = 1'b1;
                end
            end
            swpt_pkg::S_SHIFT_RD: begin
                cmd.rd_ptr_next = 1'b1;
            end
            swpt_pkg::S_SHIFT_WR: begin
                cmd.wr_shift = 1'b1;
                cmd.ptr_inc  = !stat.shift_last;
            end
            swpt_pkg::S_TOP_WR: begin
                cmd.wr_top = 1'b1;
            end
            swpt_pkg::S_RESP: begin
                cmd.out_load = stat.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/swpt_dp.sv
// datapath of the move-to-front stack: entry memory, fill count, search
// pointer, key compare and output register
// depends on swpt_pkg; controlled by swpt_ctrl
module swpt_dp #(
    parameter int DEPTH       = 16,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  swpt_pkg::in_word_t          s_word,
    output swpt_pkg::out_word_t         m_word,
    output logic                        m_valid,
    input  logic                        m_ready,
    input  logic [swpt_pkg::CFG_W-1:0]  compare_mask,
    input  swpt_pkg::ctrl_cmd_t         cmd,
    output swpt_pkg::dp_stat_t          stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (ENTRY_WIDTH < 32) ? ENTRY_WIDTH : 32;

    logic [ENTRY_WIDTH-1:0] mem [DEPTH];

    logic [CW-1:0]          occ_reg;
    logic [AW-1:0]          ptr_reg;
    swpt_pkg::op_t          func_reg;
    logic [ENTRY_WIDTH-1:0] key_reg;
    logic [ENTRY_WIDTH-1:0] hold_reg;
    logic [ENTRY_WIDTH-1:0] rdata_reg;
    swpt_pkg::status_t      status_reg;
    logic [swpt_pkg::DATA_W-1:0] data_reg;
    swpt_pkg::out_word_t    m_word_reg;
    logic                   m_valid_reg;

    logic [AW-1:0]          top_idx;
    logic [AW-1:0]          ptr_next;
    logic [ENTRY_WIDTH-1:0] mask_ext;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [ENTRY_WIDTH-1:0] wr_data;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   out_free;

    // index arithmetic
    assign top_idx  = AW'(occ_reg - CW'(1));
    assign ptr_next = ptr_reg + AW'(1);
    assign mask_ext = ENTRY_WIDTH'(compare_mask[MW-1:0]);
    assign out_free = !m_valid_reg || m_ready;

    // status to the controller
    always_comb begin
        stat.func       = func_reg;
        stat.is_empty   = (occ_reg == '0);
        stat.is_full    = (occ_reg == CW'(DEPTH));
        stat.hit        = ((rdata_reg & mask_ext) == (key_reg & mask_ext));
        stat.at_top     = (ptr_reg == top_idx);
        stat.ptr_zero   = (ptr_reg == '0);
        stat.shift_last = (ptr_next == top_idx);
        stat.out_free   = out_free;
    end

    // memory write port select
    always_comb begin
        wr_en   = cmd.wr_push || cmd.wr_shift || cmd.wr_top;
        wr_addr = ptr_reg;
        wr_data = rdata_reg;
        priority if (cmd.wr_push) begin
            wr_addr = AW'(occ_reg);
            wr_data = key_reg;
        end else if (cmd.wr_top) begin
            wr_addr = top_idx;
            wr_data = hold_reg;
        end else begin
            wr_addr = ptr_reg;
            wr_data = rdata_reg;
        end
    end

    // memory read port select
    always_comb begin
        rd_en   = cmd.rd_top || cmd.rd_ptr || cmd.rd_ptr_next;
        rd_addr = ptr_reg;
        priority if (cmd.rd_top) begin
            rd_addr = top_idx;
        end else if (cmd.rd_ptr_next) begin
            rd_addr = ptr_next;
        end else begin
            rd_addr = ptr_reg;
        end
    end

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else if (cmd.occ_clr) begin
            occ_reg <= '0;
        end else if (cmd.occ_inc) begin
            occ_reg <= occ_reg + CW'(1);
        end else if (cmd.occ_dec) begin
            occ_reg <= occ_reg - CW'(1);
        end
    end

    // search and shift pointer
    always_ff @(posedge aclk) begin
        if (cmd.ptr_load_top) begin
            ptr_reg <= top_idx;
        end else if (cmd.ptr_dec) begin
            ptr_reg <= ptr_reg - AW'(1);
        end else if (cmd.ptr_inc) begin
            ptr_reg <= ptr_next;
        end
    end

    // operation, key, kept entry and result fields
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg <= s_word.func;
            key_reg  <= ENTRY_WIDTH'(s_word.value[MW-1:0]);
            data_reg <= '0;
        end else if (cmd.data_load) begin
            data_reg <= swpt_pkg::DATA_W'(rdata_reg[MW-1:0]);
        end
        if (cmd.hold_load) begin
            hold_reg <= rdata_reg;
        end
        if (cmd.status_load) begin
            status_reg <= cmd.status_val;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_word_reg.status <= status_reg;
            m_word_reg.data   <= data_reg;
            m_word_reg.fill   <= swpt_pkg::FILL_W'(occ_reg);
        end
    end

    assign m_word  = m_word_reg;
    assign m_valid = m_valid_reg;

endmodule

FILE: hw/rtl/stack_with_promote_to_top_unit.sv
// top level of the move-to-front stack: register block, controller, datapath
// depends on swpt_pkg, swpt_regs, swpt_ctrl, swpt_dp
//
// Bounded LIFO stack of DEPTH entries, ENTRY_WIDTH bits each, held in one
// single-port-write, single-port-read memory. Each input word carries push,
// pop, promote or clear and gives one result word with status, popped data and
// the fill count afterwards. Items are worked one at a time, and the memory
// gives one read and one write per cycle. A new word is taken while the
// previous result still waits in the output register. compare_mask sits at
// byte address 0; the user must write it only while the stack is idle, and
// the block itself does not enforce it.
module stack_with_promote_to_top_unit #(
    parameter int DEPTH       = 16,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input words
    input  logic                         s_valid,
    output logic                         s_ready,
    input  swpt_pkg::in_word_t           s_payload,
    // result words
    output logic                         m_valid,
    input  logic                         m_ready,
    output swpt_pkg::out_word_t          m_payload,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [swpt_pkg::PADDR_W-1:0] paddr,
    input  logic [swpt_pkg::CFG_W-1:0]   pwdata,
    output logic [swpt_pkg::CFG_W-1:0]   prdata,
    output logic                         pready
);

    logic [swpt_pkg::CFG_W-1:0] compare_mask;
    swpt_pkg::ctrl_cmd_t        cmd;
    swpt_pkg::dp_stat_t         stat;

    // configuration registers
    swpt_regs u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .compare_mask (compare_mask)
    );

    // sequencing
    swpt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // storage and compare
    swpt_dp #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_word       (s_payload),
        .m_word       (m_payload),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .compare_mask (compare_mask),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule
